// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the cache lookup checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define SALC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is low.
`define SALC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== hdl/salc_pkg.sv =====
// ----------------------------------------------------------------------------
// salc_pkg
// Types and constants shared by the set-associative LRU cache lookup.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package salc_pkg;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;

    localparam logic [CFG_IDX_W-1:0] REG_SET_INDEX_BITS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_WORDS    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WAYS           = 2'd2;

    localparam logic [3:0] RST_SET_INDEX_BITS = 4'd10;
    localparam logic [2:0] RST_BLOCK_WORDS    = 3'd0;
    localparam logic [2:0] RST_WAYS           = 3'd1;

    // address split
    localparam int         WORD_BYTES_LOG2      = 2;
    localparam logic [2:0] MAX_BLOCK_WORDS_LOG2 = 3'd4;

    // result widths
    localparam int SET_OUT_W = 10;
    localparam int WAY_OUT_W = 2;
    localparam int CNT_W     = 32;

    typedef struct packed {
        logic [3:0] set_index_bits;
        logic [2:0] block_words_log2;
        logic [2:0] ways_in_use;
    } t_cfg;

    typedef struct packed {
        logic                 hit;
        logic [SET_OUT_W-1:0] set_number;
        logic [WAY_OUT_W-1:0] way_number;
        logic [CNT_W-1:0]     access_total;
        logic [CNT_W-1:0]     hit_total;
        logic [CNT_W-1:0]     miss_total;
    } t_res;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOKUP
    } t_state;

endpackage

`default_nettype wire

// ===== hdl/salc_if.sv =====
// ----------------------------------------------------------------------------
// salc_if
// Valid/ready channels: access address in, lookup result out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface salc_addr_if #(
    parameter int ADDR_W = 32
);
    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface salc_res_if;
    logic            valid;
    logic            ready;
    salc_pkg::t_res  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hdl/set_assoc_lru_cache_lookup.sv =====
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_lookup
// Set-associative tag lookup with true LRU replacement and access counters.
// ----------------------------------------------------------------------------
// Each address word is split into block offset, set index and tag from the
// configured geometry; the set's row (valid bits, LRU ranks, tags of every
// way) lives in one RAM word. On an access the row is read in the accept
// cycle and is matched, updated and written back in the lookup state once
// the output register can take the result, when the result is loaded into
// it. The next address is taken once that write-back is done, so a lone
// read-modify-write of the set row sets the rate and back-to-back accesses
// to one set never overlap. A result waiting in the output register does
// not block the next lookup's read; a stalled output holds only the
// write-back. After reset, and after every write to a defined register, a
// clearing pass rewrites every row (all ways invalid, ranks equal to way
// numbers) with input held off. Counters survive configuration writes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module set_assoc_lru_cache_lookup #(
    parameter int MAX_SETS     = 1024,
    parameter int MAX_WAYS     = 4,
    parameter int ADDRESS_BITS = 32
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [salc_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [salc_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    salc_addr_if.sink                             i_addr,
    salc_res_if.source                            o_res
);

    import salc_pkg::*;

    // geometry
    localparam int SW     = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;  // RAM address bits
    localparam int IB_MAX = $clog2(MAX_SETS + 1) - 1;                // largest 2^b <= MAX_SETS
    localparam int WIW    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;   // way index / rank
    localparam int WCW    = $clog2(MAX_WAYS + 1);                    // way count
    localparam int TAG_W  = ADDRESS_BITS - WORD_BYTES_LOG2;
    localparam int ROW_W  = MAX_WAYS * (1 + WIW + TAG_W);

    localparam logic [SW-1:0] LAST_ROW = SW'(MAX_SETS - 1);

    // control state
    t_cfg             r_cfg,       n_cfg;
    t_state           r_state,     n_state;
    logic [SW-1:0]    r_clr_addr,  n_clr_addr;
    logic             r_out_valid, n_out_valid;
    logic [CNT_W-1:0] r_acc,       n_acc;
    logic [CNT_W-1:0] r_hits,      n_hits;
    logic [CNT_W-1:0] r_miss,      n_miss;

    // payload
    logic [SW-1:0]    r_set,  n_set;
    logic [TAG_W-1:0] r_tag,  n_tag;
    t_res             r_res,  n_res;

    // effective geometry from the raw registers
    logic [3:0]             eff_ib;
    logic [2:0]             eff_ob;
    logic [WCW-1:0]         eff_ways;
    logic [4:0]             tag_shift;
    logic [ADDRESS_BITS-1:0] addr;
    logic [ADDRESS_BITS-1:0] set_sh;
    logic [ADDRESS_BITS-1:0] tag_sh;
    logic [SW-1:0]          set_calc;
    logic                   in_acc;

    // row RAM
    logic             ram_we;
    logic [SW-1:0]    ram_waddr;
    logic [ROW_W-1:0] ram_wdata;
    logic [ROW_W-1:0] ram_rdata;
    logic [ROW_W-1:0] clr_row;
    logic [ROW_W-1:0] new_row;

    logic [MAX_WAYS-1:0]            rd_valid, nw_valid;
    logic [MAX_WAYS-1:0][WIW-1:0]   rd_rank,  nw_rank, clr_rank;
    logic [MAX_WAYS-1:0][TAG_W-1:0] rd_tags,  nw_tags;
    logic                           lk_hit;
    logic [WIW-1:0]                 lk_way;
    logic                           lk_go;

    always_comb begin
        eff_ib = (r_cfg.set_index_bits > 4'(IB_MAX)) ? 4'(IB_MAX) : r_cfg.set_index_bits;
        eff_ob = ((r_cfg.block_words_log2 > MAX_BLOCK_WORDS_LOG2) ?
                  MAX_BLOCK_WORDS_LOG2 : r_cfg.block_words_log2) + 3'(WORD_BYTES_LOG2);
        if (r_cfg.ways_in_use == 3'd0) begin
            eff_ways = WCW'(1);
        end else if (32'(r_cfg.ways_in_use) > MAX_WAYS) begin
            eff_ways = WCW'(MAX_WAYS);
        end else begin
            eff_ways = WCW'(r_cfg.ways_in_use);
        end
        tag_shift = 5'(eff_ib) + 5'(eff_ob);
    end

    assign addr     = ADDRESS_BITS'(i_addr.data);
    assign set_sh   = addr >> eff_ob;
    assign tag_sh   = addr >> tag_shift;
    assign set_calc = set_sh[SW-1:0] & ~({SW{1'b1}} << eff_ib);

    assign i_addr.ready = (r_state == S_IDLE);
    assign in_acc       = i_addr.valid && i_addr.ready;

    // cleared row: all invalid, rank = way number, tags don't matter
    always_comb begin
        for (int w = 0; w < MAX_WAYS; w++) begin
            clr_rank[w] = WIW'(w);
        end
    end
    assign clr_row = {{MAX_WAYS{1'b0}}, clr_rank, {(MAX_WAYS * TAG_W){1'b0}}};

    assign {rd_valid, rd_rank, rd_tags} = ram_rdata;
    assign new_row = {nw_valid, nw_rank, nw_tags};

    salc_ram #(
        .WIDTH (ROW_W),
        .DEPTH (MAX_SETS)
    ) u_row_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (in_acc),
        .i_raddr (set_calc),
        .o_rdata (ram_rdata)
    );

    salc_way_sel #(
        .MAX_WAYS (MAX_WAYS),
        .TAG_W    (TAG_W),
        .WIW      (WIW),
        .WCW      (WCW)
    ) u_way_sel (
        .i_valid (rd_valid),
        .i_rank  (rd_rank),
        .i_tags  (rd_tags),
        .i_tag   (r_tag),
        .i_ways  (eff_ways),
        .o_hit   (lk_hit),
        .o_way   (lk_way),
        .o_valid (nw_valid),
        .o_rank  (nw_rank),
        .o_tags  (nw_tags)
    );

    // write-back waits until the output register can take the result
    assign lk_go = (r_state == S_LOOKUP) && (!r_out_valid || o_res.ready);

    always_comb begin
        n_cfg       = r_cfg;
        n_state     = r_state;
        n_clr_addr  = r_clr_addr;
        n_out_valid = r_out_valid;
        n_acc       = r_acc;
        n_hits      = r_hits;
        n_miss      = r_miss;
        n_set       = r_set;
        n_tag       = r_tag;
        n_res       = r_res;
        ram_we      = 1'b0;
        ram_waddr   = r_clr_addr;
        ram_wdata   = clr_row;

        if (r_out_valid && o_res.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_CLEAR: begin
                ram_we = 1'b1;
                if (r_clr_addr == LAST_ROW) begin
                    n_state = S_IDLE;
                end else begin
                    n_clr_addr = r_clr_addr + SW'(1);
                end
            end
            S_IDLE: begin
                if (in_acc) begin
                    n_set   = set_calc;
                    n_tag   = tag_sh[TAG_W-1:0];
                    n_state = S_LOOKUP;
                end
            end
            S_LOOKUP: begin
                if (lk_go) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_set;
                    ram_wdata = new_row;
                    n_acc     = r_acc + CNT_W'(1);
                    if (lk_hit) begin
                        n_hits = r_hits + CNT_W'(1);
                    end else begin
                        n_miss = r_miss + CNT_W'(1);
                    end
                    n_res.hit          = lk_hit;
                    n_res.set_number   = SET_OUT_W'(r_set);
                    n_res.way_number   = WAY_OUT_W'(lk_way);
                    n_res.access_total = n_acc;
                    n_res.hit_total    = n_hits;
                    n_res.miss_total   = n_miss;
                    n_out_valid        = 1'b1;
                    n_state            = S_IDLE;
                end
            end
            default: begin
                n_state    = S_CLEAR;
                n_clr_addr = '0;
            end
        endcase

        // any defined register write flushes the cache
        if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_SET_INDEX_BITS: begin
                    n_cfg.set_index_bits = i_cfg_data[3:0];
                    n_state              = S_CLEAR;
                    n_clr_addr           = '0;
                end
                REG_BLOCK_WORDS: begin
                    n_cfg.block_words_log2 = i_cfg_data[2:0];
                    n_state                = S_CLEAR;
                    n_clr_addr             = '0;
                end
                REG_WAYS: begin
                    n_cfg.ways_in_use = i_cfg_data[2:0];
                    n_state           = S_CLEAR;
                    n_clr_addr        = '0;
                end
                default: begin
                    n_cfg = r_cfg;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.set_index_bits   <= RST_SET_INDEX_BITS;
            r_cfg.block_words_log2 <= RST_BLOCK_WORDS;
            r_cfg.ways_in_use      <= RST_WAYS;
            r_state                <= S_CLEAR;
            r_clr_addr             <= '0;
            r_out_valid            <= 1'b0;
            r_acc                  <= '0;
            r_hits                 <= '0;
            r_miss                 <= '0;
        end else begin
            r_cfg       <= n_cfg;
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_out_valid <= n_out_valid;
            r_acc       <= n_acc;
            r_hits      <= n_hits;
            r_miss      <= n_miss;
        end
    end

    always_ff @(posedge i_clk) begin
        r_set <= n_set;
        r_tag <= n_tag;
        r_res <= n_res;
    end

    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_res;

endmodule

`default_nettype wire

// ===== hdl/salc_ram.sv =====
// ----------------------------------------------------------------------------
// salc_ram
// Generic simple dual-port RAM, one write port, registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module salc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                     i_clk,
    input  wire logic                                     i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                         i_wdata,
    input  wire logic                                     i_re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output      logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== hdl/salc_way_sel.sv =====
// ----------------------------------------------------------------------------
// salc_way_sel
// Tag match, victim choice and LRU rank update for one set row.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module salc_way_sel #(
    parameter int MAX_WAYS = 4,
    parameter int TAG_W    = 30,
    parameter int WIW      = 2,
    parameter int WCW      = 3
) (
    input  wire logic [MAX_WAYS-1:0]            i_valid,
    input  wire logic [MAX_WAYS-1:0][WIW-1:0]   i_rank,
    input  wire logic [MAX_WAYS-1:0][TAG_W-1:0] i_tags,
    input  wire logic [TAG_W-1:0]               i_tag,
    input  wire logic [WCW-1:0]                 i_ways,
    output      logic                           o_hit,
    output      logic [WIW-1:0]                 o_way,
    output      logic [MAX_WAYS-1:0]            o_valid,
    output      logic [MAX_WAYS-1:0][WIW-1:0]   o_rank,
    output      logic [MAX_WAYS-1:0][TAG_W-1:0] o_tags
);

    logic [MAX_WAYS-1:0] used;
    logic [MAX_WAYS-1:0] match;
    logic [MAX_WAYS-1:0] empty;
    logic [MAX_WAYS-1:0] oldest;
    logic [MAX_WAYS-1:0] pick;
    logic [WIW-1:0]      way_rank;

    always_comb begin
        for (int w = 0; w < MAX_WAYS; w++) begin
            used[w]   = (WCW'(w) < i_ways);
            match[w]  = used[w] && i_valid[w] && (i_tags[w] == i_tag);
            empty[w]  = used[w] && !i_valid[w];
            // ranks of the ways in use form a permutation, so rank zero is the LRU way
            oldest[w] = used[w] && (i_rank[w] == '0);
        end
        o_hit = |match;
        if (o_hit) begin
            pick = match;
        end else if (|empty) begin
            pick = empty;
        end else begin
            pick = oldest;
        end
        // lowest way wins
        o_way = '0;
        for (int w = MAX_WAYS - 1; w >= 0; w--) begin
            if (pick[w]) begin
                o_way = WIW'(w);
            end
        end
    end

    assign way_rank = i_rank[o_way];

    always_comb begin
        o_valid = i_valid;
        o_tags  = i_tags;
        for (int w = 0; w < MAX_WAYS; w++) begin
            if (used[w] && (i_rank[w] > way_rank)) begin
                o_rank[w] = i_rank[w] - WIW'(1);
            end else begin
                o_rank[w] = i_rank[w];
            end
        end
        o_rank[o_way]  = WIW'(i_ways - WCW'(1));
        o_valid[o_way] = 1'b1;
        o_tags[o_way]  = i_tag;
    end

endmodule

`default_nettype wire

// ===== hdl/salc_checker.sv =====
// ----------------------------------------------------------------------------
// salc_checker
// Port-level checks for the cache lookup, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module salc_checker (
    input wire logic                            i_clk,
    input wire logic                            i_rst_n,
    input wire logic                            i_cfg_we,
    input wire logic [salc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    salc_addr_if.sink                           i_addr,
    salc_res_if.source                          o_res
);

    import salc_pkg::*;

    logic flush_wr;
    logic out_stall;
    logic in_taken;
    logic totals_ok;

    assign flush_wr = i_cfg_we && ((i_cfg_idx == REG_SET_INDEX_BITS) ||
                                   (i_cfg_idx == REG_BLOCK_WORDS) ||
                                   (i_cfg_idx == REG_WAYS));

    assign out_stall = o_res.valid && !o_res.ready;
    assign in_taken  = i_addr.valid && i_addr.ready;
    assign totals_ok = (o_res.data.access_total ==
                        o_res.data.hit_total + o_res.data.miss_total);

    // stalled result holds
    `SALC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_stall, o_res.valid && $stable(o_res.data))

    // every access is either a hit or a miss
    `SALC_ASSERT_NOW(a_totals, i_clk, i_rst_n, o_res.valid, totals_ok)

    // one lookup in flight: no accept right behind another
    `SALC_ASSERT_NEXT(a_single, i_clk, i_rst_n, in_taken, !i_addr.ready)

    // a flushing write starts the clearing pass
    `SALC_ASSERT_NEXT(a_flush, i_clk, i_rst_n, flush_wr, !i_addr.ready)

endmodule

bind set_assoc_lru_cache_lookup salc_checker u_salc_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .i_cfg_we  (i_cfg_we),
    .i_cfg_idx (i_cfg_idx),
    .i_addr    (i_addr),
    .o_res     (o_res)
);

`default_nettype wire
